FILE: src/assert_macros.svh
// Assertion helpers included by the RTL solver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Flag a condition that must never hold on a rising clock edge, skipped while reset is low.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: src/gjs_pkg.sv
package gjs_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DivSteps = 48;
  localparam logic [2:0]  AddrSize = 3'd0;
  localparam logic [2:0]  AddrEps  = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CP_RD, ST_CP_WR, ST_SR_RD, ST_SR_CMP, ST_SR_DEC,
    ST_SW_RD, ST_SW_W1, ST_SW_W2, ST_NM_RD, ST_NM_LD, ST_NM_DIV, ST_NM_WR,
    ST_EF_RD, ST_EF_CHK, ST_EL_RD, ST_EL_MUL, ST_EL_WR, ST_NEXT_COL,
    ST_EM_RD, ST_EM_WR
  } state_e;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [31:0] sat48(input logic signed [47:0] v);
    if (v > 48'sh0000_7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -48'sh0000_8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sh0_7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -33'sh0_8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage

FILE: src/gauss_jordan_solver.sv
// Gauss-Jordan solver, Q16.16, partial pivoting. Matrix elements load one per cycle into
// the element store; the element with tlast set starts a solve. The solve copies the
// n x (n+1) window into a working memory, then per column runs a pivot search, an
// optional row swap, pivot row normalization through a bit-serial divider and elimination,
// all limited by the single write port of the working memory. The n solution entries
// follow in row order, each once the output register is free. Input is taken only between
// solves; the element store keeps its contents across solves.
module gauss_jordan_solver
  import gjs_pkg::*;
#(
  parameter int unsigned MAX_N = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] row_index, [8:4] col_index, [40:9] element_value, [47:41] zero
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] result_row, [35:4] solution_value, [39:36] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned Words = MAX_N * (MAX_N + 1);
  localparam int unsigned AW    = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned NW    = $clog2(MAX_N + 1);

  function automatic logic [AW-1:0] addr_of(input logic [NW-1:0] r, input logic [NW-1:0] c);
    return AW'(AW'(r) * AW'(MAX_N + 1) + AW'(c));
  endfunction

  // configuration
  logic [4:0]  size_q;
  logic [15:0] eps_q;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 5'd16;
      eps_q  <= 16'd1;
    end else if (cfg_wr) begin
      if (paddr == AddrSize) size_q <= pwdata[4:0];
      if (paddr == AddrEps) eps_q <= pwdata[15:0];
    end
  end
  always_comb begin
    unique case (paddr)
      AddrSize: prdata = {27'd0, size_q};
      AddrEps:  prdata = {16'd0, eps_q};
      default:  prdata = 32'd0;
    endcase
  end

  logic [NW-1:0] n;
  always_comb begin
    if (size_q == 5'd0) n = NW'(1);
    else if (32'(size_q) > MAX_N) n = NW'(MAX_N);
    else n = NW'(size_q);
  end

  // memories
  logic [31:0]   store_mem [Words];
  logic [31:0]   work_mem  [Words];
  logic          st_we, wk_we;
  logic [AW-1:0] st_waddr, st_raddr, wk_waddr, wk_raddr_a, wk_raddr_b;
  logic [31:0]   st_wdata, wk_wdata, st_rdata_q, rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (st_we) store_mem[st_waddr] <= st_wdata;
    st_rdata_q <= store_mem[st_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (wk_we) work_mem[wk_waddr] <= wk_wdata;
    rd_a_q <= work_mem[wk_raddr_a];
    rd_b_q <= work_mem[wk_raddr_b];
  end

  // control and datapath registers
  state_e               state_q, state_d;
  logic [NW-1:0]        i_q, i_d, row_q, row_d, col_q, col_d, best_q, best_d;
  logic [31:0]          piv_q, piv_d, pmag_q, pmag_d, f_q, f_d, tmp_q, tmp_d;
  logic signed [63:0]   prod_q, prod_d;
  logic [31:0]          rem_q, rem_d, dvs_q, dvs_d;
  logic [47:0]          quo_q, quo_d;
  logic [5:0]           cnt_q, cnt_d;
  logic                 neg_q, neg_d;
  logic                 ov_q, ov_d, olast_q, olast_d;
  logic [3:0]           orow_q, orow_d;
  logic [31:0]          oval_q, oval_d;

  logic [32:0]          dv_t;
  logic [31:0]          dv_mag;
  logic [31:0]          qres;
  logic signed [31:0]   prodq;
  logic                 in_ok;

  assign in_ok = (32'(s_axis_tdata[3:0]) < MAX_N) && (32'(s_axis_tdata[8:4]) <= MAX_N);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; row_q <= row_d; col_q <= col_d; best_q <= best_d;
    piv_q <= piv_d; pmag_q <= pmag_d; f_q <= f_d; tmp_q <= tmp_d;
    prod_q <= prod_d; rem_q <= rem_d; dvs_q <= dvs_d; quo_q <= quo_d;
    cnt_q <= cnt_d; neg_q <= neg_d; olast_q <= olast_d;
    orow_q <= orow_d; oval_q <= oval_d;
  end

  always_comb begin
    dv_t   = {rem_q, quo_q[47]};
    dv_mag = mag32(rd_a_q);
    prodq  = signed'(sat48(prod_q[63:16]));
    if (neg_q) qres = (quo_q > 48'h0000_8000_0000) ? 32'h8000_0000 : (32'd0 - quo_q[31:0]);
    else qres = (quo_q > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : quo_q[31:0];
  end

  always_comb begin
    state_d = state_q;
    i_d = i_q; row_d = row_q; col_d = col_q; best_d = best_q;
    piv_d = piv_q; pmag_d = pmag_q; f_d = f_q; tmp_d = tmp_q;
    prod_d = prod_q; rem_d = rem_q; dvs_d = dvs_q; quo_d = quo_q;
    cnt_d = cnt_q; neg_d = neg_q;
    ov_d = ov_q; olast_d = olast_q; orow_d = orow_q; oval_d = oval_q;
    s_axis_tready = 1'b0;
    st_we = 1'b0; st_waddr = addr_of(NW'(s_axis_tdata[3:0]), NW'(s_axis_tdata[8:4]));
    st_wdata = s_axis_tdata[40:9];
    st_raddr = addr_of(row_q, col_q);
    wk_we = 1'b0; wk_waddr = addr_of(row_q, col_q); wk_wdata = st_rdata_q;
    wk_raddr_a = addr_of(row_q, col_q); wk_raddr_b = addr_of(best_q, col_q);
    if (ov_q && m_axis_tready) ov_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          st_we = in_ok;
          if (s_axis_tlast) begin
            row_d = '0; col_d = '0;
            state_d = ST_CP_RD;
          end
        end
      end
      ST_CP_RD: state_d = ST_CP_WR;
      ST_CP_WR: begin
        wk_we = 1'b1;
        if (col_q == n) begin
          col_d = '0;
          if (row_q == n - 1'b1) begin
            i_d = '0; row_d = '0;
            state_d = ST_SR_RD;
          end else begin
            row_d = row_q + 1'b1;
            state_d = ST_CP_RD;
          end
        end else begin
          col_d = col_q + 1'b1;
          state_d = ST_CP_RD;
        end
      end
      ST_SR_RD: begin
        wk_raddr_a = addr_of(row_q, i_q);
        state_d = ST_SR_CMP;
      end
      ST_SR_CMP: begin
        if (row_q == i_q || dv_mag > pmag_q) begin
          best_d = row_q; pmag_d = dv_mag; piv_d = rd_a_q;
        end
        if (row_q == n - 1'b1) state_d = ST_SR_DEC;
        else begin
          row_d = row_q + 1'b1;
          state_d = ST_SR_RD;
        end
      end
      ST_SR_DEC: begin
        col_d = '0;
        if (pmag_q < {16'd0, eps_q} || piv_q == 32'd0) state_d = ST_NEXT_COL;
        else if (best_q != i_q) state_d = ST_SW_RD;
        else state_d = ST_NM_RD;
      end
      ST_SW_RD: begin
        wk_raddr_a = addr_of(i_q, col_q);
        state_d = ST_SW_W1;
      end
      ST_SW_W1: begin
        wk_we = 1'b1; wk_waddr = addr_of(best_q, col_q); wk_wdata = rd_a_q;
        tmp_d = rd_b_q;
        state_d = ST_SW_W2;
      end
      ST_SW_W2: begin
        wk_we = 1'b1; wk_waddr = addr_of(i_q, col_q); wk_wdata = tmp_q;
        if (col_q == n) begin
          col_d = '0;
          state_d = ST_NM_RD;
        end else begin
          col_d = col_q + 1'b1;
          state_d = ST_SW_RD;
        end
      end
      ST_NM_RD: begin
        wk_raddr_a = addr_of(i_q, col_q);
        state_d = ST_NM_LD;
      end
      ST_NM_LD: begin
        quo_d = {dv_mag, 16'd0};
        rem_d = '0;
        dvs_d = pmag_q;
        neg_d = rd_a_q[31] ^ piv_q[31];
        cnt_d = '0;
        state_d = ST_NM_DIV;
      end
      ST_NM_DIV: begin
        // one quotient bit per cycle
        if (dv_t >= {1'b0, dvs_q}) begin
          rem_d = 32'(dv_t - {1'b0, dvs_q});
          quo_d = {quo_q[46:0], 1'b1};
        end else begin
          rem_d = dv_t[31:0];
          quo_d = {quo_q[46:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'(DivSteps - 1)) state_d = ST_NM_WR;
      end
      ST_NM_WR: begin
        wk_we = 1'b1; wk_waddr = addr_of(i_q, col_q); wk_wdata = qres;
        if (col_q == n) begin
          row_d = '0;
          state_d = ST_EF_RD;
        end else begin
          col_d = col_q + 1'b1;
          state_d = ST_NM_RD;
        end
      end
      ST_EF_RD: begin
        wk_raddr_a = addr_of(row_q, i_q);
        if (row_q == i_q) begin
          if (row_q == n - 1'b1) state_d = ST_NEXT_COL;
          else row_d = row_q + 1'b1;
        end else state_d = ST_EF_CHK;
      end
      ST_EF_CHK: begin
        f_d = rd_a_q;
        col_d = i_q;
        if (dv_mag < {16'd0, eps_q}) begin
          if (row_q == n - 1'b1) state_d = ST_NEXT_COL;
          else begin
            row_d = row_q + 1'b1;
            state_d = ST_EF_RD;
          end
        end else state_d = ST_EL_RD;
      end
      ST_EL_RD: begin
        wk_raddr_a = addr_of(i_q, col_q);
        wk_raddr_b = addr_of(row_q, col_q);
        state_d = ST_EL_MUL;
      end
      ST_EL_MUL: begin
        prod_d = signed'(rd_a_q) * signed'(f_q);
        tmp_d = rd_b_q;
        state_d = ST_EL_WR;
      end
      ST_EL_WR: begin
        wk_we = 1'b1;
        wk_waddr = addr_of(row_q, col_q);
        wk_wdata = sat33(33'(signed'(tmp_q)) - 33'(prodq));
        if (col_q == n) begin
          if (row_q == n - 1'b1) state_d = ST_NEXT_COL;
          else begin
            row_d = row_q + 1'b1;
            state_d = ST_EF_RD;
          end
        end else begin
          col_d = col_q + 1'b1;
          state_d = ST_EL_RD;
        end
      end
      ST_NEXT_COL: begin
        row_d = '0;
        if (i_q == n - 1'b1) state_d = ST_EM_RD;
        else begin
          row_d = i_q + 1'b1;
          i_d = i_q + 1'b1;
          state_d = ST_SR_RD;
        end
      end
      ST_EM_RD: begin
        wk_raddr_a = addr_of(row_q, n);
        // wait until the output register is free
        if (!ov_q || m_axis_tready) state_d = ST_EM_WR;
      end
      ST_EM_WR: begin
        ov_d = 1'b1;
        oval_d = rd_a_q;
        orow_d = 4'(row_q);
        olast_d = (row_q == n - 1'b1);
        if (row_q == n - 1'b1) state_d = ST_IDLE;
        else begin
          row_d = row_q + 1'b1;
          state_d = ST_EM_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'd0, oval_q, orow_q};
  assign m_axis_tlast  = olast_q;

`include "assert_macros.svh"

  `ASSERT_NEVER(a_work_wr_busy, clk_i, rst_ni, wk_we && (state_q == ST_IDLE), "work write in idle")
  `ASSERT_CLK(a_div_bound, clk_i, rst_ni, (state_q == ST_NM_DIV) |-> (cnt_q < 6'(DivSteps)), "divider overrun")
  `ASSERT_CLK(a_out_src, clk_i, rst_ni, $rose(m_axis_tvalid) |-> ($past(state_q) == ST_EM_WR), "result without readout")

endmodule

FILE: sim/gjs_checker.sv
`timescale 1ns / 100ps

module gjs_checker
  import gjs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [47:0] s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,
  input  logic        m_tlast_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  typedef struct packed {
    logic [3:0]  row;
    logic [31:0] value;
    logic        last;
  } solution_t;

  solution_t        solution_q[$];
  logic      [31:0] elem_store[16][17];
  logic      [4:0]  size_reg;
  logic      [15:0] eps_reg;

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // Floor after the 16-bit shift: arithmetic shift rounds toward minus infinity.
  function automatic logic [31:0] fx_mul(input logic [31:0] a, input logic [31:0] b);
    longint p;
    p = longint'($signed(a)) * longint'($signed(b));
    return clamp32(p >>> 16);
  endfunction

  function automatic logic [31:0] fx_div(input logic [31:0] a, input logic [31:0] p);
    longint q;
    q = (longint'($signed(a)) * 64'sd65536) / longint'($signed(p));
    return clamp32(q);
  endfunction

  task automatic solve_window();
    logic [31:0] w[16][17];
    logic [31:0] piv, f, t;
    int          n, best;
    solution_t   s;
    n = (size_reg == 0) ? 1 : ((size_reg > 16) ? 16 : int'(size_reg));
    for (int r = 0; r < n; r++)
      for (int c = 0; c <= n; c++) w[r][c] = elem_store[r][c];
    for (int i = 0; i < n; i++) begin
      best = i;
      for (int r = i + 1; r < n; r++)
        if (abs32(w[r][i]) > abs32(w[best][i])) best = r;
      if (abs32(w[best][i]) < {16'd0, eps_reg} || w[best][i] == 32'd0) continue;
      if (best != i) begin
        for (int c = 0; c <= n; c++) begin
          t = w[i][c];
          w[i][c] = w[best][c];
          w[best][c] = t;
        end
      end
      piv = w[i][i];
      for (int c = 0; c <= n; c++) w[i][c] = fx_div(w[i][c], piv);
      for (int r = 0; r < n; r++) begin
        if (r == i || abs32(w[r][i]) < {16'd0, eps_reg}) continue;
        f = w[r][i];
        for (int c = i; c <= n; c++)
          w[r][c] = clamp32(longint'($signed(w[r][c])) - longint'($signed(fx_mul(w[i][c], f))));
      end
    end
    for (int k = 0; k < n; k++) begin
      s.row   = k[3:0];
      s.value = w[k][n];
      s.last  = (k == n - 1);
      solution_q = {solution_q, s};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    solution_t got, want;
    if (!rst_ni) begin
      solution_q.delete();
      size_reg   = 5'd16;
      eps_reg    = 16'd1;
      fail_cnt_o = 0;
      for (int r = 0; r < 16; r++)
        for (int c = 0; c < 17; c++) elem_store[r][c] = 32'd0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i)
          AddrSize: size_reg = pwdata_i[4:0];
          AddrEps:  eps_reg  = pwdata_i[15:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tdata_i[8:4] <= 5'd16) elem_store[s_tdata_i[3:0]][s_tdata_i[8:4]] = s_tdata_i[40:9];
        if (s_tlast_i) solve_window();
      end
      if (m_tvalid_i && m_tready_i) begin
        got.row   = m_tdata_i[3:0];
        got.value = m_tdata_i[35:4];
        got.last  = m_tlast_i;
        if (solution_q.size() == 0) begin
          $display("%0t unexpected result: row %0d value %h last %b",
                   $time, got.row, got.value, got.last);
          fail_cnt_o = fail_cnt_o + 1;
        end else begin
          want = solution_q.pop_front();
          if (got != want) begin
            $display("%0t mismatch: expected row %0d value %h last %b, got row %0d value %h last %b",
                     $time, want.row, want.value, want.last, got.row, got.value, got.last);
            fail_cnt_o = fail_cnt_o + 1;
          end
        end
      end
    end
    pending_o = solution_q.size();
  end

endmodule

FILE: sim/tb_gauss_jordan_solver.sv
`timescale 1ns / 100ps

module tb_gauss_jordan_solver
  import gjs_pkg::*;
;

  localparam int WatchLimit = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_cnt;
  int pending;
  int items_sent;
  int send_idle_pct;
  int recv_idle_pct;
  int val_mode;
  int stall_cnt;
  bit loaded[16][17];

  gauss_jordan_solver #(.MAX_N(16)) i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  gjs_checker i_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tlast_i(s_axis_tlast),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tlast_i(m_axis_tlast),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WatchLimit) begin
      $display("** gauss_jordan_solver: FAILED **");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value(input bit diag);
    logic [31:0] v;
    int          sel;
    sel = (val_mode == 1) ? 0 : ((val_mode == 2) ? $urandom_range(1, 3) : $urandom_range(0, 9));
    case (sel)
      0: v = 32'd0;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'h8000_0000;
      3: v = $urandom();
      default: v = $urandom_range(0, 32'h7FFFF) - 32'h40000;
    endcase
    // bias the diagonal so most systems are well conditioned
    if (diag && sel > 3 && $urandom_range(0, 3) != 0) v = v + 32'h0008_0000;
    return v;
  endfunction

  task automatic send_elem(input int r, input int c, input logic [31:0] v, input bit done);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, v, c[4:0], r[3:0]};
    s_axis_tlast  <= done;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (c <= 16) loaded[r][c] = 1'b1;
    items_sent++;
    if (items_sent < 150) begin
      send_idle_pct = 31; recv_idle_pct = 52;
    end else if (items_sent < 300) begin
      send_idle_pct = 52; recv_idle_pct = 31;
    end else begin
      send_idle_pct = 0; recv_idle_pct = 0;
    end
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold the sender until every solution has drained, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_solve(input logic [4:0] sz, input logic [15:0] eps, input bit full);
    int n;
    drain();
    apb_write(AddrSize, {27'd0, sz});
    apb_write(AddrEps, {16'd0, eps});
    n = (sz == 0) ? 1 : ((sz > 16) ? 16 : int'(sz));
    for (int r = 0; r < n; r++)
      for (int c = 0; c <= n; c++)
        if (full || !loaded[r][c] || $urandom_range(0, 9) == 0)
          send_elem(r, c, pick_value(r == c), 1'b0);
    // noise: stray columns, including ones past the store
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3))
        send_elem($urandom_range(0, 15), $urandom_range(0, 31), $urandom(), 1'b0);
    if ($urandom_range(0, 1) == 0)
      send_elem($urandom_range(0, 15), $urandom_range(17, 31), $urandom(), 1'b1);
    else
      send_elem($urandom_range(0, n - 1), n, pick_value(1'b0), 1'b1);
  endtask

  initial begin
    int   szr;
    logic [15:0] er;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    items_sent    = 0;
    send_idle_pct = 31;
    recv_idle_pct = 52;
    stall_cnt     = 0;
    val_mode      = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // zero pivot with zero epsilon, extreme values and saturation, maximal epsilon, size 0 and full size
    val_mode = 1; run_solve(5'd1, 16'd0, 1'b1);
    val_mode = 2; run_solve(5'd1, 16'd1, 1'b1);
    val_mode = 0; run_solve(5'd2, 16'hFFFF, 1'b1);
    val_mode = 2; run_solve(5'd3, 16'd1, 1'b1);
    val_mode = 0; run_solve(5'd0, 16'd0, 1'b1);
    run_solve(5'd16, 16'd1, 1'b1);

    while (items_sent < 460) begin
      case ($urandom_range(0, 9))
        0:       szr = ($urandom_range(0, 1) != 0) ? 16 : $urandom_range(17, 31);
        1:       szr = 0;
        default: szr = $urandom_range(1, 5);
      endcase
      case ($urandom_range(0, 5))
        0:       er = 16'd0;
        1:       er = 16'hFFFF;
        2:       er = $urandom();
        default: er = $urandom_range(1, 64);
      endcase
      run_solve(szr[4:0], er, (szr >= 1 && szr <= 5) && $urandom_range(0, 2) != 0);
    end

    drain();
    if (fail_cnt == 0 && pending == 0) begin
      $display("** gauss_jordan_solver: PASSED **");
    end else begin
      $display("** gauss_jordan_solver: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/gjs_pkg.sv
src/gauss_jordan_solver.sv
sim/gjs_checker.sv
sim/tb_gauss_jordan_solver.sv
